[rtl/core/drs_pkg.sv]
package drs_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int PRUNE_EVERY = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PCNT_W      = $clog2(PRUNE_EVERY + 1);
    localparam int SLOT_W      = 4;
    localparam int WINDOW_W    = 31;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = WINDOW_W'(2000);

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_PRUNE = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [63:0] origin_addr_hi;
        logic [63:0] origin_addr_lo;
        logic [63:0] target_addr_hi;
        logic [63:0] target_addr_lo;
        logic [15:0] request_seq;
        logic [31:0] time_ms;
    } drs_req_t;

    typedef struct packed {
        logic              suppressed;
        logic [SLOT_W-1:0] marked_slot;
    } drs_rsp_t;

    typedef struct packed {
        logic [63:0] origin_hi;
        logic [63:0] origin_lo;
        logic [63:0] target_hi;
        logic [63:0] target_lo;
        logic [15:0] seq;
        logic [31:0] seen_time;
    } drs_entry_t;

    localparam int ENTRY_W = $bits(drs_entry_t);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_DONE
    } drs_state_t;

endpackage

[rtl/core/drs_entry_ram.sv]
module drs_entry_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/duplicate_request_suppressor.sv]
// Duplicate route-request suppressor.
//
// s_*: request channel (valid/ready). cmd check looks up originator,
//   destination and sequence number; cmd prune only ages out stale entries.
// m_*: one response per request: suppressed flag and the slot written.
// cfg_*: write of the suppression window in ms, taken at any time; change it
//   only while no request is in flight.
//
// One request is processed at a time. The entry RAM (one read port) is
// walked once per request: every one of the 16 entries is read and checked,
// then a new entry is written back, then the response register is loaded.
// A suppressed request or a prune skips the write-back. m_valid rises in
// the same cycle as s_ready returns high, so a new request is taken only
// after the previous one's response is loaded. A stalled response holds
// the next request in its final cycle until the pending response is taken.
//
// Reset clears all entry valid flags, reloads the prune countdown and sets the
// window back to 2000 ms; entry contents are not cleared.
module duplicate_request_suppressor (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  drs_pkg::drs_req_t      s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output drs_pkg::drs_rsp_t      m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [30:0]            cfg_data
);

    import drs_pkg::*;

    drs_state_t              state_reg, state_next;
    drs_req_t                req_reg;
    logic                    prune_now_reg;
    logic [PCNT_W-1:0]       pcnt_reg;
    logic [WINDOW_W-1:0]     window_reg;
    logic [TABLE_DEPTH-1:0]  valid_reg, valid_next;
    logic [CNT_W-1:0]        idx_reg, idx_next;

    logic                    hit_reg, hit_next;
    logic                    free_found_reg, free_found_next;
    logic [IDX_W-1:0]        free_slot_reg, free_slot_next;
    logic                    best_found_reg, best_found_next;
    logic [IDX_W-1:0]        best_slot_reg, best_slot_next;
    logic [WINDOW_W-1:0]     best_age_reg, best_age_next;

    logic                    m_valid_reg;
    drs_rsp_t                m_data_reg;

    logic                    s_fire;
    logic                    ram_rd_en;
    logic [IDX_W-1:0]        ram_rd_addr;
    logic                    ram_wr_en;
    logic [ENTRY_W-1:0]      ram_rd_raw;
    drs_entry_t              ram_rd_data;
    drs_entry_t              ram_wr_data;

    logic [IDX_W-1:0]        eval_idx;
    logic [31:0]             age;
    logic                    age_neg;
    logic                    entry_vld;
    logic                    aged_out;
    logic                    eff_vld;
    logic                    key_match;
    logic [IDX_W-1:0]        slot_sel;
    logic                    out_load;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    drs_entry_ram #(
        .DEPTH (TABLE_DEPTH),
        .WIDTH (ENTRY_W)
    ) u_entry_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_sel),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_raw)
    );

    assign ram_rd_data = drs_entry_t'(ram_rd_raw);

    always_comb begin
        ram_wr_data.origin_hi = req_reg.origin_addr_hi;
        ram_wr_data.origin_lo = req_reg.origin_addr_lo;
        ram_wr_data.target_hi = req_reg.target_addr_hi;
        ram_wr_data.target_lo = req_reg.target_addr_lo;
        ram_wr_data.seq       = req_reg.request_seq;
        ram_wr_data.seen_time = req_reg.time_ms;
    end

    // entry under evaluation: the one read in the previous scan cycle
    assign eval_idx  = IDX_W'(idx_reg - CNT_W'(1));
    assign age       = req_reg.time_ms - ram_rd_data.seen_time;
    assign age_neg   = age[31];
    assign entry_vld = valid_reg[eval_idx];
    assign aged_out  = entry_vld && !age_neg && (age[WINDOW_W-1:0] >= window_reg);
    assign eff_vld   = entry_vld && !(prune_now_reg && aged_out);
    assign key_match = (ram_rd_data.seq == req_reg.request_seq)
                    && (ram_rd_data.origin_hi == req_reg.origin_addr_hi)
                    && (ram_rd_data.origin_lo == req_reg.origin_addr_lo)
                    && (ram_rd_data.target_hi == req_reg.target_addr_hi)
                    && (ram_rd_data.target_lo == req_reg.target_addr_lo);

    always_comb begin
        priority if (free_found_reg) begin
            slot_sel = free_slot_reg;
        end else if (best_found_reg) begin
            slot_sel = best_slot_reg;
        end else begin
            slot_sel = '0;
        end
    end

    assign out_load = !m_valid_reg || m_ready;

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        valid_next      = valid_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_slot_next  = free_slot_reg;
        best_found_next = best_found_reg;
        best_slot_next  = best_slot_reg;
        best_age_next   = best_age_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = idx_reg[IDX_W-1:0];
        ram_wr_en       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    state_next      = ST_SCAN;
                    idx_next        = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    best_found_next = 1'b0;
                end
            end
            ST_SCAN: begin
                if (idx_reg != CNT_W'(TABLE_DEPTH)) begin
                    ram_rd_en = 1'b1;
                end
                if (idx_reg != '0) begin
                    if (prune_now_reg && aged_out) begin
                        valid_next[eval_idx] = 1'b0;
                    end
                    if (eff_vld && key_match && !age_neg
                            && (age[WINDOW_W-1:0] < window_reg)) begin
                        hit_next = 1'b1;
                    end
                    if (!eff_vld) begin
                        if (!free_found_reg) begin
                            free_found_next = 1'b1;
                            free_slot_next  = eval_idx;
                        end
                    end else if (!age_neg && (!best_found_reg
                            || (age[WINDOW_W-1:0] > best_age_reg))) begin
                        best_found_next = 1'b1;
                        best_slot_next  = eval_idx;
                        best_age_next   = age[WINDOW_W-1:0];
                    end
                end
                idx_next = idx_reg + CNT_W'(1);
                if (idx_reg == CNT_W'(TABLE_DEPTH)) begin
                    idx_next = idx_reg;
                    if (req_reg.cmd == CMD_PRUNE || hit_next) begin
                        state_next = ST_DONE;
                    end else begin
                        state_next = ST_WRITE;
                    end
                end
            end
            ST_WRITE: begin
                ram_wr_en            = 1'b1;
                valid_next[slot_sel] = 1'b1;
                state_next           = ST_DONE;
            end
            ST_DONE: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            pcnt_reg      <= PCNT_W'(PRUNE_EVERY);
            window_reg    <= WINDOW_RESET;
            prune_now_reg <= 1'b0;
            idx_reg       <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
            if (cfg_valid && cfg_ready) begin
                window_reg <= cfg_data;
            end
            if (s_fire) begin
                if (s_data.cmd == CMD_PRUNE || pcnt_reg <= PCNT_W'(1)) begin
                    prune_now_reg <= 1'b1;
                    pcnt_reg      <= PCNT_W'(PRUNE_EVERY);
                end else begin
                    prune_now_reg <= 1'b0;
                    pcnt_reg      <= pcnt_reg - PCNT_W'(1);
                end
            end
            if (state_reg == ST_DONE && out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            req_reg <= s_data;
        end
        hit_reg        <= hit_next;
        free_found_reg <= free_found_next;
        free_slot_reg  <= free_slot_next;
        best_found_reg <= best_found_next;
        best_slot_reg  <= best_slot_next;
        best_age_reg   <= best_age_next;
        if (state_reg == ST_DONE && out_load) begin
            m_data_reg.suppressed <= (req_reg.cmd == CMD_CHECK) && hit_reg;
            if (req_reg.cmd == CMD_PRUNE || hit_reg) begin
                m_data_reg.marked_slot <= '0;
            end else begin
                m_data_reg.marked_slot <= SLOT_W'(slot_sel);
            end
        end
    end

endmodule
